/* rtl/lsm_pkg.sv */
`timescale 1ns / 1ps

package lsm_pkg;

  localparam int CNT_W = 64;
  localparam int OP_W  = 4;
  localparam int BIX_W = 4;

  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [1:0] {
    OC_SUCCESS     = 2'd0,
    OC_TIMEOUT     = 2'd1,
    OC_UNAVAILABLE = 2'd2,
    OC_OTHER_ERROR = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    cnt_t            duration_us;
    logic [1:0]      outcome;
  } in_t;

  typedef struct packed {
    logic             accepted;
    cnt_t             request_count;
    cnt_t             duration_sum;
    cnt_t             min_duration;
    cnt_t             max_duration;
    cnt_t             success_count;
    cnt_t             timeout_count;
    cnt_t             error_count;
    logic [BIX_W-1:0] bucket_index;
    cnt_t             bucket_count;
    logic             counter_saturated;
    logic             histogram_saturated;
  } out_t;

endpackage

/* rtl/lsm_hist_ram.sv */
`timescale 1ns / 1ps

module lsm_hist_ram #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output lsm_pkg::cnt_t              rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  lsm_pkg::cnt_t              wr_data,
  output logic                       busy
);
  import lsm_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  cnt_t              mem [DEPTH];
  cnt_t              rd_data_r;
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // zeroing sweep after reset, one bin per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

/* rtl/latency_statistics_monitor.sv */
`timescale 1ns / 1ps
// an accepted beat is registered in stage 1 and then in the result register; it waits
// in stage 1 while the result register holds a beat that out_ready has not taken
// throughput: one observation per cycle if in_ready is high; histogram RMW is bypassed
// reset: synchronous active-low rst_n zeroes every counter and flag; the histogram
// memory is then swept to zero, all NUM_OPERATIONS*NUM_BUCKETS bins, with in_ready low

module latency_statistics_monitor #(
  parameter int NUM_OPERATIONS = 8,
  parameter int NUM_BUCKETS    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lsm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lsm_pkg::out_t out_data
);
  import lsm_pkg::*;

  localparam int HDEPTH   = NUM_OPERATIONS * NUM_BUCKETS;
  localparam int ADDR_W   = $clog2(HDEPTH);
  localparam int BKT_W    = $clog2(NUM_BUCKETS);
  localparam int OP_IDX_W = (NUM_OPERATIONS > 1) ? $clog2(NUM_OPERATIONS) : 1;

  // ---------------------------------------------------------------------------
  // input side: bucket select and histogram address, memory read at accept
  // ---------------------------------------------------------------------------
  logic                in_fire;
  logic                in_op_ok;
  logic [OP_IDX_W-1:0] in_idx;
  logic [6:0]          in_bit_len;
  logic [BKT_W-1:0]    in_bkt;
  logic [ADDR_W-1:0]   in_addr;

  // stage 1 holds the accepted beat while its record is updated
  logic                s1_valid_r;
  logic                s1_ok_r;
  logic [OP_IDX_W-1:0] s1_idx_r;
  cnt_t                s1_dur_r;
  outcome_e            s1_oc_r;
  logic [BKT_W-1:0]    s1_bkt_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic                s1_adv;
  logic                s1_wr;

  // histogram bypass for back-to-back beats to the same bin
  logic                fwd_hit_r;
  cnt_t                fwd_data_r;

  logic                hist_busy;
  cnt_t                hist_rd_data;

  // per-class records
  cnt_t req_r  [NUM_OPERATIONS];
  cnt_t sum_r  [NUM_OPERATIONS];
  cnt_t min_r  [NUM_OPERATIONS];
  cnt_t max_r  [NUM_OPERATIONS];
  cnt_t succ_r [NUM_OPERATIONS];
  cnt_t tmo_r  [NUM_OPERATIONS];
  cnt_t err_r  [NUM_OPERATIONS];
  cnt_t obs_r;
  logic ctr_sat_r;
  logic hist_sat_r;

  logic out_valid_r;
  out_t out_data_r;
  out_t out_nxt;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_wr    = s1_adv && s1_ok_r;
  assign in_ready = !hist_busy && (!s1_valid_r || s1_adv);
  assign in_fire  = in_valid && in_ready;

  assign in_op_ok = {1'b0, in_data.operation} < (OP_W + 1)'(NUM_OPERATIONS);
  assign in_idx   = OP_IDX_W'(in_data.operation);

  // bit length of the duration, capped at the last bucket
  always_comb begin
    in_bit_len = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (in_data.duration_us[i]) begin
        in_bit_len = 7'(i + 1);
      end
    end
    if (in_bit_len > 7'(NUM_BUCKETS - 1)) begin
      in_bkt = BKT_W'(NUM_BUCKETS - 1);
    end else begin
      in_bkt = BKT_W'(in_bit_len);
    end
  end

  // class-major bin address, invalid classes park on bin zero
  assign in_addr = in_op_ok
                 ? ADDR_W'((ADDR_W + 1)'(in_idx) * (ADDR_W + 1)'(NUM_BUCKETS)
                           + (ADDR_W + 1)'(in_bkt))
                 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ok_r   <= in_op_ok;
      s1_idx_r  <= in_idx;
      s1_dur_r  <= in_data.duration_us;
      s1_oc_r   <= outcome_e'(in_data.outcome);
      s1_bkt_r  <= in_bkt;
      s1_addr_r <= in_addr;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: record update
  // ---------------------------------------------------------------------------
  cnt_t cur_req, cur_sum, cur_min, cur_max, cur_succ, cur_tmo, cur_err;
  cnt_t new_req, new_sum, new_min, new_max, new_succ, new_tmo, new_err;
  cnt_t sel_cnt, sel_new;
  cnt_t hist_cur, hist_new;
  logic req_sat, sum_sat, sel_sat, obs_sat, hist_full;
  logic [CNT_W:0] sum_wide;
  cnt_t new_obs;
  logic ctr_sat_nxt, hist_sat_nxt;

  assign cur_req  = req_r[s1_idx_r];
  assign cur_sum  = sum_r[s1_idx_r];
  assign cur_min  = min_r[s1_idx_r];
  assign cur_max  = max_r[s1_idx_r];
  assign cur_succ = succ_r[s1_idx_r];
  assign cur_tmo  = tmo_r[s1_idx_r];
  assign cur_err  = err_r[s1_idx_r];

  assign req_sat = (cur_req == CNT_MAX);
  assign new_req = req_sat ? cur_req : cur_req + 1'b1;

  assign sum_wide = {1'b0, cur_sum} + {1'b0, s1_dur_r};
  assign sum_sat  = sum_wide[CNT_W];
  assign new_sum  = sum_sat ? CNT_MAX : sum_wide[CNT_W-1:0];

  // first request of a class always seeds the minimum
  assign new_min = ((new_req == cnt_t'(1)) || (s1_dur_r < cur_min)) ? s1_dur_r : cur_min;
  assign new_max = (s1_dur_r > cur_max) ? s1_dur_r : cur_max;

  // only one outcome counter moves per beat
  always_comb begin
    case (s1_oc_r) inside
      OC_SUCCESS:                     sel_cnt = cur_succ;
      OC_TIMEOUT:                     sel_cnt = cur_tmo;
      OC_UNAVAILABLE, OC_OTHER_ERROR: sel_cnt = cur_err;
      default:                        sel_cnt = cur_err;
    endcase
  end

  assign sel_sat  = (sel_cnt == CNT_MAX);
  assign sel_new  = sel_sat ? sel_cnt : sel_cnt + 1'b1;
  assign new_succ = (s1_oc_r == OC_SUCCESS) ? sel_new : cur_succ;
  assign new_tmo  = (s1_oc_r == OC_TIMEOUT) ? sel_new : cur_tmo;
  assign new_err  = ((s1_oc_r == OC_UNAVAILABLE) || (s1_oc_r == OC_OTHER_ERROR))
                  ? sel_new : cur_err;

  assign obs_sat = (obs_r == CNT_MAX);
  assign new_obs = obs_sat ? obs_r : obs_r + 1'b1;

  // bin value: bypass the write that landed the same edge as our read
  assign hist_cur  = fwd_hit_r ? fwd_data_r : hist_rd_data;
  assign hist_full = (hist_cur == CNT_MAX);
  assign hist_new  = hist_full ? hist_cur : hist_cur + 1'b1;

  assign ctr_sat_nxt  = ctr_sat_r  | (s1_ok_r & (obs_sat | req_sat | sum_sat | sel_sat));
  assign hist_sat_nxt = hist_sat_r | (s1_ok_r & hist_full);

  always_comb begin
    out_nxt = '0;
    if (s1_ok_r) begin
      out_nxt.accepted      = 1'b1;
      out_nxt.request_count = new_req;
      out_nxt.duration_sum  = new_sum;
      out_nxt.min_duration  = new_min;
      out_nxt.max_duration  = new_max;
      out_nxt.success_count = new_succ;
      out_nxt.timeout_count = new_tmo;
      out_nxt.error_count   = new_err;
      out_nxt.bucket_index  = BIX_W'(s1_bkt_r);
      out_nxt.bucket_count  = hist_new;
    end
    out_nxt.counter_saturated   = ctr_sat_nxt;
    out_nxt.histogram_saturated = hist_sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OPERATIONS; i++) begin
        req_r[i]  <= '0;
        sum_r[i]  <= '0;
        min_r[i]  <= '0;
        max_r[i]  <= '0;
        succ_r[i] <= '0;
        tmo_r[i]  <= '0;
        err_r[i]  <= '0;
      end
      obs_r      <= '0;
      ctr_sat_r  <= 1'b0;
      hist_sat_r <= 1'b0;
    end else if (s1_wr) begin
      req_r[s1_idx_r]  <= new_req;
      sum_r[s1_idx_r]  <= new_sum;
      min_r[s1_idx_r]  <= new_min;
      max_r[s1_idx_r]  <= new_max;
      succ_r[s1_idx_r] <= new_succ;
      tmo_r[s1_idx_r]  <= new_tmo;
      err_r[s1_idx_r]  <= new_err;
      obs_r            <= new_obs;
      ctr_sat_r        <= ctr_sat_nxt;
      hist_sat_r       <= hist_sat_nxt;
    end
  end

  // bypass is refreshed only when a new read is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_r <= s1_wr && (s1_addr_r == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data_r <= hist_new;
    end
  end

  lsm_hist_ram #(
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (hist_rd_data),
    .wr_en   (s1_wr),
    .wr_addr (s1_addr_r),
    .wr_data (hist_new),
    .busy    (hist_busy)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_no_accept_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    hist_busy |-> !in_ready)
    else $error("input taken while histogram sweep runs");

  a_ctr_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(ctr_sat_r))
    else $error("counter saturation flag dropped");

  a_hist_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(hist_sat_r))
    else $error("histogram saturation flag dropped");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.accepted) |->
      (out_data_r.min_duration <= out_data_r.max_duration))
    else $error("class minimum above maximum");

  a_bin_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.accepted) |->
      (out_data_r.bucket_count != '0) && (out_data_r.request_count != '0))
    else $error("accepted beat reports empty bin or request count");

endmodule
